/* src/kcl_pkg.sv */
// Package for the keypad code lock: code length, register indexes, reset values
// and the structs passed between the config block, the lock core and the top level.
// No dependencies.
`timescale 1ns / 1ps
package kcl_pkg;

  localparam int CODE_LEN = 6;
  localparam int DIGIT_W  = 4;
  localparam int CODE_W   = 24;
  localparam int POS_W    = 3;
  localparam int MISS_W   = 4;
  localparam int LTMR_W   = 16;
  localparam int BTMR_W   = 12;
  localparam int OTMR_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SECRET_CODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TICKS    = 3'd4;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CODE_W-1:0] RST_SECRET_CODE   = 24'h321CBA;
  localparam logic [MISS_W-1:0] RST_MISS_LIMIT    = 4'd3;
  localparam logic [LTMR_W-1:0] RST_LOCKOUT_TICKS = 16'd10000;
  localparam logic [BTMR_W-1:0] RST_BLINK_TICKS   = 12'd300;
  localparam logic [OTMR_W-1:0] RST_OPEN_TICKS    = 16'd4000;

  typedef struct packed {
    logic [CODE_W-1:0] secret_code;
    logic [MISS_W-1:0] miss_limit;
    logic [LTMR_W-1:0] lockout_ticks;
    logic [BTMR_W-1:0] blink_ticks;
    logic [OTMR_W-1:0] open_ticks;
  } kcl_cfg_t;

  typedef struct packed {
    logic              door_open;
    logic              locked_out;
    logic              alarm_on;
    logic [POS_W-1:0]  entered_count;
    logic [MISS_W-1:0] miss_count;
    logic              code_accepted;
    logic              key_rejected;
    logic              key_taken;
  } kcl_res_t;

endpackage

/* src/kcl_cfg_regs.sv */
// Configuration register file of the keypad code lock.
// Depends on kcl_pkg.
`timescale 1ns / 1ps
module kcl_cfg_regs import kcl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output kcl_cfg_t              cfg
);

  kcl_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.secret_code   <= RST_SECRET_CODE;
      cfg_r.miss_limit    <= RST_MISS_LIMIT;
      cfg_r.lockout_ticks <= RST_LOCKOUT_TICKS;
      cfg_r.blink_ticks   <= RST_BLINK_TICKS;
      cfg_r.open_ticks    <= RST_OPEN_TICKS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SECRET_CODE:   cfg_r.secret_code   <= cfg_data[CODE_W-1:0];
        REG_MISS_LIMIT:    cfg_r.miss_limit    <= cfg_data[MISS_W-1:0];
        REG_LOCKOUT_TICKS: cfg_r.lockout_ticks <= cfg_data[LTMR_W-1:0];
        REG_BLINK_TICKS:   cfg_r.blink_ticks   <= cfg_data[BTMR_W-1:0];
        REG_OPEN_TICKS:    cfg_r.open_ticks    <= cfg_data[OTMR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* src/kcl_lock_core.sv */
// Lock state and single-pass update logic: entry position, misses, door and lockout timers.
// Depends on kcl_pkg; driven from the input stage of the top level.
`timescale 1ns / 1ps
module kcl_lock_core import kcl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic               op,
  input  logic [DIGIT_W-1:0] key_code,
  input  kcl_cfg_t           cfg,
  output kcl_res_t           res_nxt
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [MISS_W-1:0] misses_r, misses_nxt;
  logic              lock_r, lock_nxt;
  logic [LTMR_W-1:0] lock_tmr_r, lock_tmr_nxt;
  logic [BTMR_W-1:0] blink_tmr_r, blink_tmr_nxt;
  logic              phase_r, phase_nxt;
  logic              door_r, door_nxt;
  logic [OTMR_W-1:0] open_tmr_r, open_tmr_nxt;

  logic [DIGIT_W*8-1:0] code_ext;
  logic [DIGIT_W-1:0]   want;
  logic [POS_W:0]       pos_inc;
  logic [MISS_W-1:0]    miss_sat;
  logic [LTMR_W-1:0]    elapsed;
  logic [BTMR_W-1:0]    blink_inc;
  logic                 accepted, rejected, taken;

  assign code_ext  = {{(DIGIT_W*8-CODE_W){1'b0}}, cfg.secret_code};
  assign want      = code_ext[{pos_r, 2'b00} +: DIGIT_W];
  assign pos_inc   = {1'b0, pos_r} + 1'b1;
  assign miss_sat  = (misses_r == {MISS_W{1'b1}}) ? misses_r : misses_r + 1'b1;
  assign elapsed   = (lock_tmr_r == {LTMR_W{1'b1}}) ? lock_tmr_r : lock_tmr_r + 1'b1;
  assign blink_inc = (blink_tmr_r == {BTMR_W{1'b1}}) ? blink_tmr_r : blink_tmr_r + 1'b1;

  always_comb begin
    pos_nxt       = pos_r;
    misses_nxt    = misses_r;
    lock_nxt      = lock_r;
    lock_tmr_nxt  = lock_tmr_r;
    blink_tmr_nxt = blink_tmr_r;
    phase_nxt     = phase_r;
    door_nxt      = door_r;
    open_tmr_nxt  = open_tmr_r;
    accepted      = 1'b0;
    rejected      = 1'b0;
    taken         = 1'b0;
    if (op == OP_KEY) begin
      if (!door_r && !lock_r) begin
        taken = 1'b1;
        if (key_code == want) begin
          if (pos_inc >= (POS_W+1)'(CODE_LEN)) begin
            pos_nxt      = '0;
            door_nxt     = 1'b1;
            open_tmr_nxt = cfg.open_ticks;
            accepted     = 1'b1;
          end else begin
            pos_nxt = pos_inc[POS_W-1:0];
          end
        end else begin
          rejected   = 1'b1;
          pos_nxt    = '0;
          misses_nxt = miss_sat;
          if (miss_sat >= cfg.miss_limit) begin
            lock_nxt      = 1'b1;
            lock_tmr_nxt  = '0;
            blink_tmr_nxt = '0;
            phase_nxt     = 1'b0;
          end
        end
      end
    end else begin
      if (door_r) begin
        if (open_tmr_r <= OTMR_W'(1)) begin
          open_tmr_nxt = '0;
          door_nxt     = 1'b0;
          misses_nxt   = '0;
          pos_nxt      = '0;
        end else begin
          open_tmr_nxt = open_tmr_r - 1'b1;
        end
      end else if (lock_r) begin
        lock_tmr_nxt = elapsed;
        if (elapsed >= cfg.lockout_ticks) begin
          lock_nxt      = 1'b0;
          lock_tmr_nxt  = '0;
          blink_tmr_nxt = '0;
          phase_nxt     = 1'b0;
          misses_nxt    = '0;
          pos_nxt       = '0;
        end else if (blink_inc >= cfg.blink_ticks) begin
          phase_nxt     = !phase_r;
          blink_tmr_nxt = '0;
        end else begin
          blink_tmr_nxt = blink_inc;
        end
      end
    end
    res_nxt.door_open     = door_nxt;
    res_nxt.locked_out    = lock_nxt;
    res_nxt.alarm_on      = lock_nxt && phase_nxt;
    res_nxt.entered_count = pos_nxt;
    res_nxt.miss_count    = misses_nxt;
    res_nxt.code_accepted = accepted;
    res_nxt.key_rejected  = rejected;
    res_nxt.key_taken     = taken;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      misses_r    <= '0;
      lock_r      <= 1'b0;
      lock_tmr_r  <= '0;
      blink_tmr_r <= '0;
      phase_r     <= 1'b0;
      door_r      <= 1'b0;
      open_tmr_r  <= '0;
    end else if (fire) begin
      pos_r       <= pos_nxt;
      misses_r    <= misses_nxt;
      lock_r      <= lock_nxt;
      lock_tmr_r  <= lock_tmr_nxt;
      blink_tmr_r <= blink_tmr_nxt;
      phase_r     <= phase_nxt;
      door_r      <= door_nxt;
      open_tmr_r  <= open_tmr_nxt;
    end
  end

endmodule

/* src/keypad_code_lock_with_lockout.sv */
// Top level of the six-digit keypad code lock with lockout alarm.
// Depends on kcl_pkg, kcl_cfg_regs and kcl_lock_core.
//
// Usage:
//   in_*  : one request per key press (in_op = 0, in_key_code) or timer tick (in_op = 1).
//   out_* : exactly one result per request, showing the lock state after that request,
//           plus the code_accepted / key_rejected / key_taken pulses.
//   cfg_* : register writes (secret code, miss limit, lockout, blink and open ticks),
//           taken every cycle; write only while no request is in flight.
// Path: an accepted request is held in the input register, then its result is
// loaded into the result register once that register is free; the update logic
// between the two registers is one pass.
// Throughput: one request per cycle, sustained while out_ready is high.
// Reset: rst_n low clears lock state, door closed, no lockout; registers take
// their default values; no result is pending.
// Stall: while out_ready is low the result register holds; one more request
// waits in the input register, after which in_ready drops until the result
// is taken.
`timescale 1ns / 1ps
module keypad_code_lock_with_lockout import kcl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [DIGIT_W-1:0]    in_key_code,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_door_open,
  output logic                  out_locked_out,
  output logic                  out_alarm_on,
  output logic [POS_W-1:0]      out_entered_count,
  output logic [MISS_W-1:0]     out_miss_count,
  output logic                  out_code_accepted,
  output logic                  out_key_rejected,
  output logic                  out_key_taken,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  kcl_cfg_t           cfg;
  kcl_res_t           res_nxt, res_r;
  logic               stage_valid_r;
  logic               stage_op_r;
  logic [DIGIT_W-1:0] stage_key_r;
  logic               out_valid_r;
  logic               out_free;
  logic               stage_go;

  assign out_free = !out_valid_r || out_ready;
  assign stage_go = stage_valid_r && out_free;
  assign in_ready = !stage_valid_r || stage_go;

  kcl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kcl_lock_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (stage_go),
    .op       (stage_op_r),
    .key_code (stage_key_r),
    .cfg      (cfg),
    .res_nxt  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= stage_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_op_r  <= in_op;
      stage_key_r <= in_key_code;
    end
    if (stage_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_door_open     = res_r.door_open;
  assign out_locked_out    = res_r.locked_out;
  assign out_alarm_on      = res_r.alarm_on;
  assign out_entered_count = res_r.entered_count;
  assign out_miss_count    = res_r.miss_count;
  assign out_code_accepted = res_r.code_accepted;
  assign out_key_rejected  = res_r.key_rejected;
  assign out_key_taken     = res_r.key_taken;

  a_open_xor_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_door_open && out_locked_out))
    else $error("door open during lockout");

  a_accept_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_code_accepted) |-> (out_door_open && out_key_taken
                                          && (out_entered_count == '0)))
    else $error("accepted code did not open the door");

  a_reject_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_key_rejected) |-> (out_key_taken && !out_code_accepted
                                         && (out_entered_count == '0)))
    else $error("rejected key inconsistent");

  a_alarm_in_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alarm_on) |-> out_locked_out)
    else $error("alarm outside lockout");

endmodule

/* sim/keypad_code_lock_with_lockout_tb.sv */
// Testbench for keypad_code_lock_with_lockout: sends key and tick requests, keeps a
// behavioral copy of the lock to predict every result and checks each field.
// Depends on kcl_pkg and the lock RTL.
`timescale 1ns / 1ps
module keypad_code_lock_with_lockout_tb;
  import kcl_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 165;
  localparam logic [DIGIT_W-1:0] KEY_STAR = 4'd14;
  localparam logic [DIGIT_W-1:0] KEY_HASH = 4'd15;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_op = OP_KEY;
  logic [DIGIT_W-1:0]    in_key_code = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_door_open;
  logic                  out_locked_out;
  logic                  out_alarm_on;
  logic [POS_W-1:0]      out_entered_count;
  logic [MISS_W-1:0]     out_miss_count;
  logic                  out_code_accepted;
  logic                  out_key_rejected;
  logic                  out_key_taken;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SECRET_CODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  kcl_cfg_t lock_cfg = '{secret_code: RST_SECRET_CODE, miss_limit: RST_MISS_LIMIT,
                         lockout_ticks: RST_LOCKOUT_TICKS, blink_ticks: RST_BLINK_TICKS,
                         open_ticks: RST_OPEN_TICKS};
  logic [POS_W-1:0]  lk_pos = '0;
  logic [MISS_W-1:0] lk_misses = '0;
  logic              lk_lockout = 1'b0;
  logic [LTMR_W-1:0] lk_lock_elapsed = '0;
  logic [BTMR_W-1:0] lk_blink_elapsed = '0;
  logic              lk_blink = 1'b0;
  logic              lk_open = 1'b0;
  logic [OTMR_W-1:0] lk_open_left = '0;

  kcl_res_t lock_states_due[$];
  kcl_res_t due;
  int errors = 0;
  int n_requests = 0;
  int n_effective = 0;
  int n_checked = 0;
  int n_opens = 0;
  int n_lockouts = 0;
  int burst_left = 0;
  int cycles = 0;
  logic [9:0] rx_phase = '0;

  keypad_code_lock_with_lockout uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_key_code(in_key_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_door_open(out_door_open),
    .out_locked_out(out_locked_out),
    .out_alarm_on(out_alarm_on),
    .out_entered_count(out_entered_count),
    .out_miss_count(out_miss_count),
    .out_code_accepted(out_code_accepted),
    .out_key_rejected(out_key_rejected),
    .out_key_taken(out_key_taken),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, lock_states_due.size());
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    if (rx_phase[8]) begin
      out_ready <= 1'b1;
    end else if (rx_phase[9]) begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready <= ($urandom_range(0, 3) == 0);
    end
  end

  function automatic logic [DIGIT_W-1:0] code_digit(input int pos);
    return DIGIT_W'(lock_cfg.secret_code >> (DIGIT_W * pos));
  endfunction

  function automatic logic [DIGIT_W-1:0] wrong_digit(input int pos);
    logic [DIGIT_W-1:0] k;
    k = DIGIT_W'($urandom);
    if (k == code_digit(pos)) k = k ^ DIGIT_W'($urandom_range(1, 15));
    return k;
  endfunction

  task automatic lock_update(input logic op, input logic [DIGIT_W-1:0] key,
                             output kcl_res_t res);
    int elapsed;
    int blink;
    res = '0;
    if (op == OP_KEY) begin
      if (!lk_open && !lk_lockout) begin
        res.key_taken = 1'b1;
        if (key == code_digit(lk_pos)) begin
          if (int'(lk_pos) + 1 >= CODE_LEN) begin
            lk_pos = '0;
            lk_open = 1'b1;
            lk_open_left = lock_cfg.open_ticks;
            res.code_accepted = 1'b1;
            n_opens++;
          end else begin
            lk_pos = lk_pos + 1'b1;
          end
        end else begin
          res.key_rejected = 1'b1;
          lk_pos = '0;
          if (lk_misses != '1) lk_misses = lk_misses + 1'b1;
          if (lk_misses >= lock_cfg.miss_limit) begin
            lk_lockout = 1'b1;
            lk_lock_elapsed = '0;
            lk_blink_elapsed = '0;
            lk_blink = 1'b0;
            n_lockouts++;
          end
        end
      end
    end else if (lk_open) begin
      if (lk_open_left <= 1) begin
        lk_open_left = '0;
        lk_open = 1'b0;
        lk_misses = '0;
        lk_pos = '0;
      end else begin
        lk_open_left = lk_open_left - 1'b1;
      end
    end else if (lk_lockout) begin
      elapsed = int'(lk_lock_elapsed) + 1;
      if (elapsed > 16'hFFFF) elapsed = 16'hFFFF;
      lk_lock_elapsed = LTMR_W'(elapsed);
      if (elapsed >= int'(lock_cfg.lockout_ticks)) begin
        lk_lockout = 1'b0;
        lk_lock_elapsed = '0;
        lk_blink_elapsed = '0;
        lk_blink = 1'b0;
        lk_misses = '0;
        lk_pos = '0;
      end else begin
        blink = int'(lk_blink_elapsed) + 1;
        if (blink > 12'hFFF) blink = 12'hFFF;
        if (blink >= int'(lock_cfg.blink_ticks)) begin
          lk_blink = ~lk_blink;
          lk_blink_elapsed = '0;
        end else begin
          lk_blink_elapsed = BTMR_W'(blink);
        end
      end
    end
    res.door_open = lk_open;
    res.locked_out = lk_lockout;
    res.alarm_on = lk_lockout & lk_blink;
    res.entered_count = lk_pos;
    res.miss_count = lk_misses;
  endtask

  task automatic send_request(input logic op, input logic [DIGIT_W-1:0] key);
    kcl_res_t res;
    logic busy;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key_code <= key;
    do @(posedge clk); while (!in_ready);
    busy = lk_open | lk_lockout;
    lock_update(op, key, res);
    lock_states_due.push_back(res);
    n_requests++;
    if (op == OP_TICK ? busy : res.key_taken) n_effective++;
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (lock_states_due.size() != 0) @(posedge clk);
  endtask

  task automatic apply_config(input kcl_cfg_t c);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] vals [5];
    idx = '{REG_SECRET_CODE, REG_MISS_LIMIT, REG_LOCKOUT_TICKS, REG_BLINK_TICKS,
            REG_OPEN_TICKS};
    vals = '{CFG_DATA_W'(c.secret_code), CFG_DATA_W'(c.miss_limit),
             CFG_DATA_W'(c.lockout_ticks), CFG_DATA_W'(c.blink_ticks),
             CFG_DATA_W'(c.open_ticks)};
    wait_drained();
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    lock_cfg = c;
  endtask

  task automatic enter_code(input int n);
    for (int i = 0; i < n; i++) send_request(OP_KEY, code_digit(i));
  endtask

  task automatic drain_lock();
    while (lk_open || lk_lockout) send_request(OP_TICK, DIGIT_W'($urandom));
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 50) begin
      $display("mismatch at result %0d: %s got %0d want %0d", n_checked, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (lock_states_due.size() == 0) begin
        report_mismatch("result with no request pending", 1, 0);
      end else begin
        due = lock_states_due.pop_front();
        n_checked++;
        check_field("door_open", out_door_open, due.door_open);
        check_field("locked_out", out_locked_out, due.locked_out);
        check_field("alarm_on", out_alarm_on, due.alarm_on);
        check_field("entered_count", out_entered_count, due.entered_count);
        check_field("miss_count", out_miss_count, due.miss_count);
        check_field("code_accepted", out_code_accepted, due.code_accepted);
        check_field("key_rejected", out_key_rejected, due.key_rejected);
        check_field("key_taken", out_key_taken, due.key_taken);
      end
    end
  end

  task automatic test_reset_code();
    send_request(OP_TICK, KEY_HASH);
    enter_code(2);
    send_request(OP_KEY, wrong_digit(2));
    enter_code(CODE_LEN - 1);
    apply_config('{secret_code: RST_SECRET_CODE, miss_limit: RST_MISS_LIMIT,
                   lockout_ticks: RST_LOCKOUT_TICKS, blink_ticks: RST_BLINK_TICKS,
                   open_ticks: 16'd6});
    send_request(OP_KEY, code_digit(CODE_LEN - 1));
    send_request(OP_KEY, KEY_HASH);
    drain_lock();
  endtask

  task automatic test_lockout_blink();
    apply_config('{secret_code: CODE_W'($urandom), miss_limit: 4'd2, lockout_ticks: 16'd7,
                   blink_ticks: 12'd2, open_ticks: 16'd3});
    send_request(OP_KEY, wrong_digit(0));
    enter_code(1);
    send_request(OP_KEY, wrong_digit(1));
    send_request(OP_KEY, KEY_STAR);
    drain_lock();
    enter_code(CODE_LEN);
    drain_lock();
  endtask

  task automatic test_zero_settings();
    apply_config('{secret_code: '1, miss_limit: '0, lockout_ticks: 16'd5,
                   blink_ticks: '0, open_ticks: '0});
    send_request(OP_KEY, wrong_digit(0));
    drain_lock();
    apply_config('{secret_code: '1, miss_limit: '0, lockout_ticks: '0,
                   blink_ticks: '0, open_ticks: '0});
    send_request(OP_KEY, wrong_digit(0));
    drain_lock();
    enter_code(CODE_LEN);
    send_request(OP_KEY, KEY_HASH);
    drain_lock();
  endtask

  task automatic test_full_scale();
    apply_config('{secret_code: '0, miss_limit: '1, lockout_ticks: '1,
                   blink_ticks: '1, open_ticks: 16'd20});
    enter_code(3);
    send_request(OP_KEY, wrong_digit(3));
    enter_code(CODE_LEN);
    drain_lock();
    for (int i = 1; i <= 15; i++) send_request(OP_KEY, DIGIT_W'(i));
    send_request(OP_KEY, '0);
    repeat (40) send_request(OP_TICK, DIGIT_W'($urandom));
    apply_config('{secret_code: '0, miss_limit: '1, lockout_ticks: 16'd50,
                   blink_ticks: '1, open_ticks: 16'd20});
    drain_lock();
  endtask

  task automatic test_random_settings(input int phases);
    kcl_cfg_t c;
    int start;
    int n;
    for (int p = 0; p < phases; p++) begin
      c.secret_code = CODE_W'($urandom);
      c.miss_limit = ($urandom_range(0, 4) == 0) ? MISS_W'($urandom)
                                                 : MISS_W'($urandom_range(0, 5));
      c.lockout_ticks = LTMR_W'($urandom_range(0, 30));
      c.blink_ticks = BTMR_W'($urandom_range(0, 6));
      c.open_ticks = OTMR_W'($urandom_range(0, 12));
      apply_config(c);
      start = n_requests;
      while (n_requests - start < RANDOM_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            n = $urandom_range(1, CODE_LEN);
            enter_code(n);
            if (n < CODE_LEN && $urandom_range(0, 1)) send_request(OP_KEY, wrong_digit(n));
          end
          6, 7: begin
            repeat ($urandom_range(1, 40)) send_request(OP_TICK, DIGIT_W'($urandom));
          end
          default: begin
            repeat ($urandom_range(1, 4)) begin
              send_request(1'($urandom_range(0, 1)), DIGIT_W'($urandom));
            end
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_code();
    test_lockout_blink();
    test_zero_settings();
    test_full_scale();
    test_random_settings(4);
    wait_drained();
    repeat (4) @(posedge clk);
    $display("covered %0d requests (%0d keys taken or busy ticks), %0d results checked",
             n_requests, n_effective, n_checked);
    $display("door opened %0d times, %0d lockouts, over reset, zero, full-scale and random setups",
             n_opens, n_lockouts);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
